@@ rtl/core/glob_pattern_matcher_assert.svh @@
// assertion macros for the glob pattern matcher
`ifndef GLOB_PATTERN_MATCHER_ASSERT_SVH
`define GLOB_PATTERN_MATCHER_ASSERT_SVH

// property checked on every rising edge of clk, off during reset
`define GPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every rising edge of clk, also during reset
`define GPM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/gpm_pkg.sv @@
package gpm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int PAT_BYTES       = 32;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int LEN_W           = 6;
  localparam int SET_W           = 256;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHARS_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 3'd4;

  // pattern syntax bytes
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QUEST  = 8'h3F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [8:0] PREV_NONE = 9'd256;

  typedef enum logic [1:0] {
    EL_LIT,
    EL_ANY,
    EL_STAR,
    EL_CLASS
  } elem_kind_t;

  typedef struct packed {
    elem_kind_t       kind;
    logic [7:0]       lit;
    logic [SET_W-1:0] set;
  } gpm_elem_t;

  typedef enum logic [2:0] {
    C_START,
    C_TOP,
    C_ESC,
    C_CLS_FIRST,
    C_CLS,
    C_DASH,
    C_LOAD,
    C_DONE
  } comp_state_t;

  // compiler status toward the matcher
  typedef struct packed {
    logic busy;
    logic load;
    logic bad;
  } gpm_comp_stat_t;

endpackage

@@ rtl/core/gpm_if.sv @@
interface gpm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_byte;
  logic       name_end;
  modport source (output valid, name_byte, name_end, input ready);
  modport sink (input valid, name_byte, name_end, output ready);
endinterface

interface gpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  modport source (output valid, matched, input ready);
  modport sink (input valid, matched, output ready);
endinterface

@@ rtl/core/gpm_cell.sv @@
module gpm_cell (
  input  logic              clk,
  input  logic              we,
  input  gpm_pkg::gpm_elem_t elem_in,
  input  logic              valid,
  input  logic              live,
  input  logic [7:0]        c,
  output logic              adv,
  output logic              stay,
  output logic              star
);
  import gpm_pkg::*;

  gpm_elem_t elem;

  // element storage, loaded by the compiler
  always_ff @(posedge clk) begin
    if (we) begin
      elem <= elem_in;
    end
  end

  // advance to the next position on this byte
  always_comb begin
    case (elem.kind)
      EL_LIT:   adv = valid && live && (elem.lit == c);
      EL_ANY:   adv = valid && live;
      EL_CLASS: adv = valid && live && elem.set[c];
      default:  adv = 1'b0;
    endcase
  end

  assign star = valid && (elem.kind == EL_STAR);
  assign stay = star && live;
endmodule

@@ rtl/core/gpm_closure.sv @@
module gpm_closure #(
  parameter int W = 33
) (
  input  logic [W-1:0] raw,
  input  logic [W-1:0] prop,
  output logic [W-1:0] closed
);
  // parallel prefix: a live bit runs forward over a row of star elements
  always_comb begin
    logic [W-1:0] g;
    logic [W-1:0] p;
    logic [W-1:0] g_n;
    logic [W-1:0] p_n;
    g = raw;
    p = prop;
    for (int d = 1; d < W; d = d * 2) begin
      g_n = g;
      p_n = p;
      for (int j = d; j < W; j++) begin
        g_n[j] = g[j] | (p[j] & g[j-d]);
        p_n[j] = p[j] & p[j-d];
      end
      for (int j = 0; j < d; j++) begin
        p_n[j] = 1'b0;
      end
      g = g_n;
      p = p_n;
    end
    closed = g;
  end
endmodule

@@ rtl/core/gpm_compiler.sv @@
module gpm_compiler #(
  parameter int PATTERN_MAX = gpm_pkg::PATTERN_MAX_DEF,
  parameter int NW = $clog2(PATTERN_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [gpm_pkg::PAT_BYTES*8-1:0] pat,
  input  logic [gpm_pkg::LEN_W-1:0]     len,
  output logic                          el_we,
  output logic [NW-1:0]                 el_idx,
  output gpm_pkg::gpm_elem_t            el_data,
  output logic [NW-1:0]                 el_count,
  output gpm_pkg::gpm_comp_stat_t       stat
);
  import gpm_pkg::*;

  localparam int PW = $clog2(PAT_BYTES + 1);
  localparam int LW = (LEN_W > NW ? LEN_W : NW) + 1;
  localparam logic [LW-1:0] PMAX_L = LW'(PATTERN_MAX);
  localparam logic [LW-1:0] PBYTES_L = LW'(PAT_BYTES);

  comp_state_t state, state_next;
  logic [PW-1:0]    p, p_next;
  logic [NW-1:0]    n, n_next;
  logic [NW-1:0]    count_next;
  logic [SET_W-1:0] set_acc, set_acc_next;
  logic [8:0]       prev, prev_next;
  logic             inv, inv_next;
  logic             bad, bad_next;
  logic [LW-1:0]    len_eff;
  logic [7:0]       cur;
  logic             at_end;
  logic [SET_W-1:0] range_mask;

  // usable length: limited by the element count and the stored bytes
  always_comb begin
    len_eff = LW'(len);
    if (len_eff > PMAX_L) begin
      len_eff = PMAX_L;
    end
    if (len_eff > PBYTES_L) begin
      len_eff = PBYTES_L;
    end
  end

  // current pattern byte and end of pattern
  assign cur    = pat[p[PW-2:0]*8 +: 8];
  assign at_end = (LW'(p) >= len_eff) || (cur == 8'd0);

  // bytes from prev up to the current byte
  always_comb begin
    for (int k = 0; k < SET_W; k++) begin
      range_mask[k] = (9'(k) >= prev) && (9'(k) <= {1'b0, cur});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= C_START;
      el_count <= '0;
    end else begin
      state    <= state_next;
      el_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    p       <= p_next;
    n       <= n_next;
    set_acc <= set_acc_next;
    prev    <= prev_next;
    inv     <= inv_next;
    bad     <= bad_next;
  end

  // parse one pattern byte per cycle, except in the start, class-open, load and done states
  always_comb begin
    state_next   = state;
    p_next       = p;
    n_next       = n;
    count_next   = el_count;
    set_acc_next = set_acc;
    prev_next    = prev;
    inv_next     = inv;
    bad_next     = bad;
    el_we        = 1'b0;
    el_idx       = n;
    el_data.kind = EL_LIT;
    el_data.lit  = cur;
    el_data.set  = inv ? ~set_acc : set_acc;
    stat.busy    = 1'b1;
    stat.load    = 1'b0;
    case (state)
      C_START: begin
        p_next     = '0;
        n_next     = '0;
        bad_next   = 1'b0;
        state_next = C_TOP;
      end
      C_TOP: begin
        if (at_end || (n == NW'(PATTERN_MAX))) begin
          count_next = n;
          state_next = C_LOAD;
        end else begin
          p_next = p + 1'b1;
          case (cur)
            CH_BSLASH: state_next = C_ESC;
            CH_QUEST: begin
              el_we        = 1'b1;
              el_data.kind = EL_ANY;
              n_next       = n + 1'b1;
            end
            CH_STAR: begin
              el_we        = 1'b1;
              el_data.kind = EL_STAR;
              n_next       = n + 1'b1;
            end
            CH_LBRACK: begin
              set_acc_next = '0;
              prev_next    = PREV_NONE;
              state_next   = C_CLS_FIRST;
            end
            default: begin
              el_we  = 1'b1;
              n_next = n + 1'b1;
            end
          endcase
        end
      end
      C_ESC: begin
        if (at_end) begin
          bad_next   = 1'b1;
          count_next = n;
          state_next = C_LOAD;
        end else begin
          el_we      = 1'b1;
          n_next     = n + 1'b1;
          p_next     = p + 1'b1;
          state_next = C_TOP;
        end
      end
      C_CLS_FIRST: begin
        inv_next = !at_end && (cur == CH_BANG);
        if (!at_end && (cur == CH_BANG)) begin
          p_next = p + 1'b1;
        end
        state_next = C_CLS;
      end
      C_CLS: begin
        if (at_end) begin
          bad_next   = 1'b1;
          count_next = n;
          state_next = C_LOAD;
        end else begin
          p_next = p + 1'b1;
          case (cur)
            CH_RBRACK: begin
              el_we        = 1'b1;
              el_data.kind = EL_CLASS;
              n_next       = n + 1'b1;
              state_next   = C_TOP;
            end
            CH_DASH: state_next = C_DASH;
            default: begin
              set_acc_next      = set_acc;
              set_acc_next[cur] = 1'b1;
              prev_next         = {1'b0, cur};
            end
          endcase
        end
      end
      C_DASH: begin
        if (at_end) begin
          bad_next   = 1'b1;
          count_next = n;
          state_next = C_LOAD;
        end else begin
          set_acc_next = set_acc | range_mask;
          prev_next    = {1'b0, cur};
          p_next       = p + 1'b1;
          state_next   = C_CLS;
        end
      end
      C_LOAD: begin
        stat.load  = 1'b1;
        state_next = C_DONE;
      end
      C_DONE: stat.busy = 1'b0;
      default: state_next = C_START;
    endcase
    if (start) begin
      state_next = C_START;
    end
  end

  assign stat.bad = bad;
endmodule

@@ rtl/core/glob_pattern_matcher.sv @@
// the match flag is registered and shown in the cycle after the end-marker transfer
// throughput: one name byte or end marker per cycle; input waits while a result is stalled or the compiler is busy
// after reset or a pattern register write the compiler walks the pattern, one byte per
// cycle plus a class-open step for each class without '!', then loads, with input
// ready low
// reset is synchronous active high: empty pattern, output empty
module glob_pattern_matcher #(
  parameter int PATTERN_MAX = gpm_pkg::PATTERN_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gpm_pkg::CFG_W-1:0]     cfg_data,
  gpm_in_if.sink                        name_in,
  gpm_out_if.source                     result_out
);
  import gpm_pkg::*;
  `include "glob_pattern_matcher_assert.svh"

  localparam int NW = $clog2(PATTERN_MAX + 1);
  localparam int W  = PATTERN_MAX + 1;

  logic [PAT_BYTES*8-1:0] pat;
  logic [LEN_W-1:0]       len;
  logic                   comp_start;
  logic                   el_we;
  logic [NW-1:0]          el_idx;
  gpm_elem_t              el_data;
  logic [NW-1:0]          el_count;
  gpm_comp_stat_t         stat;
  logic [W-1:0]           live;
  logic [W-1:0]           pos_ok;
  logic [PATTERN_MAX-1:0] adv, stay, star;
  logic [W-1:0]           step_raw, step_prop, step_live;
  logic [W-1:0]           start_raw, start_live;
  logic                   ov, om;
  logic                   xfer;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pat <= '0;
      len <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CHARS_A: pat[0*CFG_W +: CFG_W] <= cfg_data;
        REG_CHARS_B: pat[1*CFG_W +: CFG_W] <= cfg_data;
        REG_CHARS_C: pat[2*CFG_W +: CFG_W] <= cfg_data;
        REG_CHARS_D: pat[3*CFG_W +: CFG_W] <= cfg_data;
        REG_LENGTH:  len <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign comp_start = cfg_we && (cfg_index <= REG_LENGTH);

  gpm_compiler #(.PATTERN_MAX(PATTERN_MAX), .NW(NW)) u_comp (
    .clk(clk), .rst(rst), .start(comp_start), .pat(pat), .len(len),
    .el_we(el_we), .el_idx(el_idx), .el_data(el_data),
    .el_count(el_count), .stat(stat)
  );

  // row of element cells
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    gpm_cell u_cell (
      .clk(clk), .we(el_we && (el_idx == NW'(i))), .elem_in(el_data),
      .valid(NW'(i) < el_count), .live(live[i]), .c(name_in.name_byte),
      .adv(adv[i]), .stay(stay[i]), .star(star[i])
    );
  end

  // raw next positions and star propagation
  always_comb begin
    step_raw  = {adv, 1'b0} | {1'b0, stay};
    step_prop = {star, 1'b0};
    start_raw = W'(1);
    for (int j = 0; j < W; j++) begin
      pos_ok[j] = NW'(j) <= el_count;
    end
  end

  gpm_closure #(.W(W)) u_step_cl (
    .raw(step_raw), .prop(step_prop), .closed(step_live));
  gpm_closure #(.W(W)) u_start_cl (
    .raw(start_raw), .prop(step_prop), .closed(start_live));

  assign name_in.ready = !stat.busy && (!ov || result_out.ready);
  assign xfer = name_in.valid && name_in.ready;

  // live position vector
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (stat.load || (xfer && name_in.name_end)) begin
      live <= start_live;
    end else if (xfer) begin
      live <= step_live;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (xfer && name_in.name_end) begin
      ov <= 1'b1;
    end else if (result_out.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer && name_in.name_end) begin
      om <= !stat.bad && live[el_count];
    end
  end

  assign result_out.valid   = ov;
  assign result_out.matched = om;

  `GPM_ASSERT(a_out_from_end, $rose(ov) |-> $past(xfer && name_in.name_end), "result without end transfer")
  `GPM_ASSERT(a_live_in_range, !stat.busy |-> ((live & ~pos_ok) == '0), "live position beyond element count")
  `GPM_ASSERT(a_restart, (xfer && name_in.name_end) |=> (live == $past(start_live)), "live set not restarted after end")
  `GPM_ASSERT(a_bad_nomatch, (xfer && name_in.name_end && stat.bad) |=> !om, "broken pattern matched")
  `GPM_ASSERT_ALWAYS(a_busy_noxfer, stat.busy |-> !name_in.ready, "input taken while compiling")
endmodule
